// ===== rtl/ljfs_pkg.sv =====
// shared types and constants for the lennard-jones force sum
package ljfs_pkg;

    localparam int MAX_ATOMS_DEF = 256;
    localparam logic [63:0] LJ_K_Q40 = 64'd1840142660;
    localparam logic signed [47:0] FORCE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] FORCE_MIN = 48'sh8000_0000_0000;

    localparam logic [8:0]  ATOM_COUNT_RST = 9'd256;
    localparam logic [23:0] SIGMA_RST      = 24'd3565158;
    localparam logic [31:0] EPS_RST        = 32'd3992977;

    localparam logic [1:0] CFG_ATOM_COUNT = 2'd0;
    localparam logic [1:0] CFG_SIGMA      = 2'd1;
    localparam logic [1:0] CFG_EPSILON    = 2'd2;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_COIN = 2'd2;

    typedef struct packed {
        logic        op;
        logic [7:0]  atom_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic [1:0]  status;
    } out_item_t;

    // shared multiplier operation codes
    typedef enum logic [1:0] {
        MUL_PLAIN,
        MUL_SHIFT32,
        MUL_SHIFT56,
        MUL_SHIFT28
    } mul_op_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_OWN,
        S_LATCH_OWN,
        S_RD_OTHER,
        S_DIFF,
        S_SQ,
        S_R2,
        S_DIV_U,
        S_U2,
        S_U3,
        S_U6,
        S_W,
        S_C,
        S_P,
        S_DIV_G,
        S_M,
        S_ACC,
        S_NEXT,
        S_DONE
    } state_t;

    // divider request and reply
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic [5:0]  frac;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

// ===== rtl/ljfs_ram.sv =====
// generic single-port ram with registered read
module ljfs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/ljfs_div.sv =====
// restoring fractional divider, one quotient bit per cycle
module ljfs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ljfs_pkg::div_req_t req,
    output ljfs_pkg::div_rsp_t rsp
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sat_reg, sat_next;
    logic [64:0] shl;
    logic        fits;

    // quotient overflows when num >= den << (64-frac)
    always_comb
    begin
        fits = (req.num >> (7'd64 - {1'b0, req.frac})) < req.den;
    end

    // one bit of long division per cycle over 64 + frac bits
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        shl       = {rem_reg, quo_reg[63]};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = 7'd64 + {1'b0, req.frac};
            busy_next = 1'b1;
            sat_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (shl >= {1'b0, den_reg})
            begin
                rem_next = 64'(shl - {1'b0, den_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shl[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // the overflow check is taken on the start cycle
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        sat_reg <= req.start ? !fits : sat_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.quo  = sat_reg ? 64'hFFFF_FFFF_FFFF_FFFF : quo_reg;

endmodule

// ===== rtl/ljfs_mul.sv =====
// shared 64x64 multiplier, one 32x32 partial product per cycle
module ljfs_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ljfs_pkg::mul_op_t  op,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    output logic               done,
    output logic               sat,
    output logic [63:0]        res
);

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic         done_reg;
    ljfs_pkg::mul_op_t op_reg;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] shifted;
    logic         hi_nz;

    // partial product select
    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    begin pa = a_reg[31:0];  pb = b_reg[31:0];  end
            2'd1:    begin pa = a_reg[31:0];  pb = b_reg[63:32]; end
            2'd2:    begin pa = a_reg[63:32]; pb = b_reg[31:0];  end
            default: begin pa = a_reg[63:32]; pb = b_reg[63:32]; end
        endcase
        pp = 64'(pa) * 64'(pb);
        case (step_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // accumulate four partial products
    always_comb
    begin
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + pp_sh;
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd3)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= busy_reg && step_reg == 3'd3;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= b;
            op_reg <= op;
        end
    end

    // final shift and saturation
    always_comb
    begin
        case (op_reg)
            ljfs_pkg::MUL_SHIFT32: shifted = acc_reg >> 32;
            ljfs_pkg::MUL_SHIFT56: shifted = acc_reg >> 56;
            ljfs_pkg::MUL_SHIFT28: shifted = acc_reg >> 28;
            default:               shifted = acc_reg;
        endcase
        hi_nz = |shifted[127:64];
    end

    assign done = done_reg;
    assign sat  = hi_nz;
    assign res  = hi_nz ? 64'hFFFF_FFFF_FFFF_FFFF : shifted[63:0];

endmodule

// ===== rtl/lennard_jones_force_sum.sv =====
// top level: atom table, pair sequencer and force accumulation
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | op, atom_index, pos_x/y/z
//  out     | output    | out_valid/out_stall | force_x/y/z, status
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// a query works through the atom pairs one after another, using the shared
// 64-bit divider (divisions of 96 and 104 steps) and the shared multiplier
// (eleven products per pair).
// reset clears control and config; the atom table is undefined until
// written. the input is stalled while an item is in work or its result
// waits in the output register.
module lennard_jones_force_sum #(
    parameter int MAX_ATOMS = ljfs_pkg::MAX_ATOMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ljfs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ljfs_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int CW = $clog2(MAX_ATOMS + 1);

    ljfs_pkg::state_t state_reg, state_next;

    logic [8:0]  atom_count_reg;
    logic [23:0] sigma_reg;
    logic [31:0] eps_reg;

    logic [AW-1:0]  own_idx_reg;
    logic [CW-1:0]  i_reg, i_next, n_reg;
    logic [1:0]     k_reg;
    logic signed [31:0] own_reg [3];
    logic signed [32:0] d_reg [3];
    logic [63:0]    mag_reg [3];
    logic [63:0]    r2_reg, u_reg, u3_reg, w_reg, g_reg;
    logic           negw_reg;
    logic signed [47:0] acc_reg [3];
    logic           sat_reg, coin_reg;
    logic           out_valid_reg;
    ljfs_pkg::out_item_t out_reg;

    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [95:0]    ram_wdata, ram_rdata;

    logic           mul_start, mul_done, mul_sat;
    ljfs_pkg::mul_op_t mul_op;
    logic [63:0]    mul_a, mul_b, mul_res;
    ljfs_pkg::div_req_t div_req;
    ljfs_pkg::div_rsp_t div_rsp;

    logic           in_fire, out_fire, idx_ok;
    logic           entry;
    logic [CW-1:0]  cnt_clip;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = state_reg != ljfs_pkg::S_IDLE || out_valid_reg;
    assign idx_ok   = {24'd0, in_data.atom_index} < 32'(MAX_ATOMS);
    assign cnt_clip = ({23'd0, atom_count_reg} > 32'(MAX_ATOMS)) ? CW'(MAX_ATOMS)
                                                                  : CW'(atom_count_reg);

    ljfs_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    ljfs_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mul_start),
        .op   (mul_op),
        .a    (mul_a),
        .b    (mul_b),
        .done (mul_done),
        .sat  (mul_sat),
        .res  (mul_res)
    );

    ljfs_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_count_reg <= ljfs_pkg::ATOM_COUNT_RST;
            sigma_reg      <= ljfs_pkg::SIGMA_RST;
            eps_reg        <= ljfs_pkg::EPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ljfs_pkg::CFG_ATOM_COUNT: atom_count_reg <= cfg_data[8:0];
                ljfs_pkg::CFG_SIGMA:      sigma_reg      <= cfg_data[23:0];
                ljfs_pkg::CFG_EPSILON:    eps_reg        <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // other entry is any i below n except own
    assign entry = i_reg < n_reg && i_reg != CW'(own_idx_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ljfs_pkg::S_IDLE:
                if (in_fire)
                begin
                    if (in_data.op == ljfs_pkg::OP_QUERY && idx_ok)
                        state_next = ljfs_pkg::S_RD_OWN;
                    else
                        state_next = ljfs_pkg::S_DONE;
                end
            ljfs_pkg::S_RD_OWN:    state_next = ljfs_pkg::S_LATCH_OWN;
            ljfs_pkg::S_LATCH_OWN: state_next = ljfs_pkg::S_NEXT;
            ljfs_pkg::S_NEXT:
                if (i_reg >= n_reg)   state_next = ljfs_pkg::S_DONE;
                else if (entry)       state_next = ljfs_pkg::S_RD_OTHER;
            ljfs_pkg::S_RD_OTHER:  state_next = ljfs_pkg::S_DIFF;
            ljfs_pkg::S_DIFF:      state_next = ljfs_pkg::S_SQ;
            ljfs_pkg::S_SQ:
                if (mul_done && k_reg == 2'd2) state_next = ljfs_pkg::S_R2;
            ljfs_pkg::S_R2:
                if (r2_reg == 64'd0) state_next = ljfs_pkg::S_NEXT;
                else                 state_next = ljfs_pkg::S_DIV_U;
            ljfs_pkg::S_DIV_U:     if (div_rsp.done) state_next = ljfs_pkg::S_U2;
            ljfs_pkg::S_U2:        if (mul_done) state_next = ljfs_pkg::S_U3;
            ljfs_pkg::S_U3:        if (mul_done) state_next = ljfs_pkg::S_U6;
            ljfs_pkg::S_U6:        if (mul_done) state_next = ljfs_pkg::S_W;
            ljfs_pkg::S_W:         state_next = ljfs_pkg::S_C;
            ljfs_pkg::S_C:         if (mul_done) state_next = ljfs_pkg::S_P;
            ljfs_pkg::S_P:         if (mul_done) state_next = ljfs_pkg::S_DIV_G;
            ljfs_pkg::S_DIV_G:     if (div_rsp.done) state_next = ljfs_pkg::S_M;
            ljfs_pkg::S_M:         if (mul_done) state_next = ljfs_pkg::S_ACC;
            ljfs_pkg::S_ACC:
                if (k_reg == 2'd2) state_next = ljfs_pkg::S_NEXT;
                else               state_next = ljfs_pkg::S_M;
            ljfs_pkg::S_DONE:      state_next = ljfs_pkg::S_IDLE;
            default:               state_next = ljfs_pkg::S_IDLE;
        endcase
    end

    // unit requests and memory access
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = own_idx_reg;
        ram_wdata = {in_data.pos_x, in_data.pos_y, in_data.pos_z};
        mul_start = 1'b0;
        mul_op    = ljfs_pkg::MUL_PLAIN;
        mul_a     = '0;
        mul_b     = '0;
        div_req   = '0;
        i_next    = i_reg;
        case (state_reg)
            ljfs_pkg::S_IDLE:
            begin
                ram_addr = in_data.atom_index[AW-1:0];
                ram_we   = in_fire && in_data.op == ljfs_pkg::OP_STORE && idx_ok;
            end
            ljfs_pkg::S_NEXT:
            begin
                ram_addr = i_reg[AW-1:0];
                if (i_reg < n_reg && !entry)
                    i_next = i_reg + CW'(1);
            end
            ljfs_pkg::S_RD_OTHER:
                ram_addr = i_reg[AW-1:0];
            ljfs_pkg::S_DIFF:
            begin
                mul_start = 1'b1;
                mul_a     = 64'(d_mag(own_reg[0], ram_rdata[95:64]));
                mul_b     = mul_a;
            end
            ljfs_pkg::S_SQ:
                if (mul_done && k_reg != 2'd2)
                begin
                    mul_start = 1'b1;
                    mul_a     = mag_reg[k_reg + 2'd1];
                    mul_b     = mag_reg[k_reg + 2'd1];
                end
            ljfs_pkg::S_R2:
                if (r2_reg != 64'd0)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = 64'(sigma_reg) * 64'(sigma_reg);
                    div_req.den   = r2_reg;
                    div_req.frac  = 6'd32;
                end
                else
                    i_next = i_reg + CW'(1);
            ljfs_pkg::S_DIV_U:
                if (div_rsp.done)
                begin
                    mul_start = 1'b1;
                    mul_op    = ljfs_pkg::MUL_SHIFT32;
                    mul_a     = div_rsp.quo;
                    mul_b     = div_rsp.quo;
                end
            ljfs_pkg::S_U2:
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_op    = ljfs_pkg::MUL_SHIFT32;
                    mul_a     = mul_res;
                    mul_b     = u_reg;
                end
            ljfs_pkg::S_U3:
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_op    = ljfs_pkg::MUL_SHIFT32;
                    mul_a     = mul_res;
                    mul_b     = mul_res;
                end
            ljfs_pkg::S_W:
            begin
                mul_start = 1'b1;
                mul_a     = ljfs_pkg::LJ_K_Q40;
                mul_b     = 64'(eps_reg);
            end
            ljfs_pkg::S_C:
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_op    = ljfs_pkg::MUL_SHIFT56;
                    mul_a     = mul_res;
                    mul_b     = w_reg;
                end
            ljfs_pkg::S_P:
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_res;
                    div_req.den   = r2_reg;
                    div_req.frac  = 6'd40;
                end
            ljfs_pkg::S_DIV_G:
                if (div_rsp.done)
                begin
                    mul_start = 1'b1;
                    mul_op    = ljfs_pkg::MUL_SHIFT28;
                    mul_a     = div_rsp.quo;
                    mul_b     = mag_reg[0];
                end
            ljfs_pkg::S_ACC:
                if (k_reg != 2'd2)
                begin
                    mul_start = 1'b1;
                    mul_op    = ljfs_pkg::MUL_SHIFT28;
                    mul_a     = g_reg;
                    mul_b     = mag_reg[k_reg + 2'd1];
                end
                else
                    i_next = i_reg + CW'(1);
            default: ;
        endcase
    end

    // magnitude of own minus other on one axis
    function automatic logic [32:0] d_mag(input logic signed [31:0] o,
                                          input logic [31:0] t);
        logic signed [32:0] d;
        d = 33'(o) - 33'(signed'(t));
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    // term from magnitude and sign, then clamp the running sum
    function automatic logic signed [47:0] add_term(input logic signed [47:0] acc,
                                                    input logic [63:0] m,
                                                    input logic neg,
                                                    output logic sat);
        logic signed [49:0] t;
        logic signed [49:0] s;
        sat = 1'b0;
        if (neg)
        begin
            if (m > 64'h8000_0000_0000)
            begin
                sat = 1'b1;
                t = 50'(ljfs_pkg::FORCE_MIN);
            end
            else
                t = -50'(signed'({1'b0, m[48:0]}));
        end
        else
        begin
            if (m > 64'h7FFF_FFFF_FFFF)
            begin
                sat = 1'b1;
                t = 50'(ljfs_pkg::FORCE_MAX);
            end
            else
                t = 50'(signed'({1'b0, m[48:0]}));
        end
        s = 50'(acc) + t;
        if (s > 50'(ljfs_pkg::FORCE_MAX))
        begin
            sat = 1'b1;
            return ljfs_pkg::FORCE_MAX;
        end
        if (s < 50'(ljfs_pkg::FORCE_MIN))
        begin
            sat = 1'b1;
            return ljfs_pkg::FORCE_MIN;
        end
        return s[47:0];
    endfunction

    logic signed [47:0] acc_new;
    logic               acc_sat;
    logic [63:0]        a12, b6;
    logic               a_sat, b_sat;

    always_comb
    begin
        acc_new = add_term(acc_reg[k_reg], mul_res, negw_reg ^ d_reg[k_reg][32], acc_sat);
    end

    // 12*u6 and 6*u3 with saturation
    always_comb
    begin
        a_sat = mul_res > 64'h1555_5555_5555_5555;
        b_sat = u3_reg > 64'h2AAA_AAAA_AAAA_AAAA;
        a12   = a_sat ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(mul_res * 64'd12);
        b6    = b_sat ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(u3_reg * 64'd6);
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ljfs_pkg::S_IDLE:
                if (in_fire)
                begin
                    own_idx_reg <= in_data.atom_index[AW-1:0];
                    n_reg       <= cnt_clip;
                    i_reg       <= '0;
                    sat_reg     <= 1'b0;
                    coin_reg    <= 1'b0;
                    for (int k = 0; k < 3; k++)
                        acc_reg[k] <= '0;
                end
            ljfs_pkg::S_LATCH_OWN:
            begin
                own_reg[0] <= ram_rdata[95:64];
                own_reg[1] <= ram_rdata[63:32];
                own_reg[2] <= ram_rdata[31:0];
            end
            ljfs_pkg::S_DIFF:
            begin
                d_reg[0]   <= 33'(own_reg[0]) - 33'(signed'(ram_rdata[95:64]));
                d_reg[1]   <= 33'(own_reg[1]) - 33'(signed'(ram_rdata[63:32]));
                d_reg[2]   <= 33'(own_reg[2]) - 33'(signed'(ram_rdata[31:0]));
                mag_reg[0] <= 64'(d_mag(own_reg[0], ram_rdata[95:64]));
                mag_reg[1] <= 64'(d_mag(own_reg[1], ram_rdata[63:32]));
                mag_reg[2] <= 64'(d_mag(own_reg[2], ram_rdata[31:0]));
                r2_reg     <= '0;
                k_reg      <= 2'd0;
            end
            ljfs_pkg::S_SQ:
                if (mul_done)
                begin
                    r2_reg <= ({1'b0, r2_reg} + {1'b0, mul_res} > 65'h0_FFFF_FFFF_FFFF_FFFF)
                              ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(r2_reg + mul_res);
                    k_reg  <= k_reg + 2'd1;
                end
            ljfs_pkg::S_R2:
                if (r2_reg == 64'd0)
                    coin_reg <= 1'b1;
            ljfs_pkg::S_DIV_U:
                if (div_rsp.done)
                begin
                    u_reg   <= div_rsp.quo;
                    sat_reg <= sat_reg | div_rsp.sat;
                end
            ljfs_pkg::S_U2:
                if (mul_done)
                    sat_reg <= sat_reg | mul_sat;
            ljfs_pkg::S_U3:
                if (mul_done)
                begin
                    u3_reg  <= mul_res;
                    sat_reg <= sat_reg | mul_sat;
                end
            ljfs_pkg::S_U6:
                if (mul_done)
                begin
                    sat_reg <= sat_reg | mul_sat | a_sat | b_sat;
                    negw_reg <= a12 < b6;
                    w_reg   <= (a12 < b6) ? 64'(b6 - a12) : 64'(a12 - b6);
                end
            ljfs_pkg::S_P:
                if (mul_done)
                    sat_reg <= sat_reg | mul_sat;
            ljfs_pkg::S_DIV_G:
                if (div_rsp.done)
                begin
                    g_reg   <= div_rsp.quo;
                    sat_reg <= sat_reg | div_rsp.sat;
                    k_reg   <= 2'd0;
                end
            ljfs_pkg::S_M:
                if (mul_done)
                begin
                    acc_reg[k_reg] <= acc_new;
                    sat_reg        <= sat_reg | mul_sat | acc_sat;
                end
            ljfs_pkg::S_ACC:
                k_reg <= k_reg + 2'd1;
            default: ;
        endcase
        if (state_reg != ljfs_pkg::S_IDLE)
            i_reg <= i_next;
    end

    // control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ljfs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ljfs_pkg::S_DONE)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ljfs_pkg::S_DONE)
        begin
            out_reg.force_x <= acc_reg[0];
            out_reg.force_y <= acc_reg[1];
            out_reg.force_z <= acc_reg[2];
            out_reg.status  <= sat_reg ? ljfs_pkg::ST_SAT
                             : (coin_reg ? ljfs_pkg::ST_COIN : ljfs_pkg::ST_OK);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sim/tb_lennard_jones_force_sum.sv =====
// testbench for the lennard-jones force sum: directed table, then random traffic against a predictor
module tb_lennard_jones_force_sum;
    timeunit 1ns;
    timeprecision 1ps;
    import ljfs_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int TABLE_SIZE = 256;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        in_item_t    item;
        bit          typed;
        out_item_t   want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_ATOM_COUNT;
    logic [31:0] cfg_data = '0;

    // predictor state
    logic signed [31:0] atom_x [TABLE_SIZE];
    logic signed [31:0] atom_y [TABLE_SIZE];
    logic signed [31:0] atom_z [TABLE_SIZE];
    bit                 stored [TABLE_SIZE];
    int                 stored_list[$];
    logic [8:0]         n_atoms = ATOM_COUNT_RST;
    logic [23:0]        sigma_q20 = SIGMA_RST;
    logic [31:0]        eps_q24 = EPS_RST;

    out_item_t   force_queue[$];
    stim_row_t   directed[$];
    int          errors = 0;
    int          cycles = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;

    lennard_jones_force_sum dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // floor(a*b / 2^sh), saturating to 64 bits
    function automatic logic [63:0] mul_scaled(input logic [63:0] a, input logic [63:0] b,
                                               input int sh, inout bit sat);
        logic [127:0] prod;
        prod = ({64'd0, a} * {64'd0, b}) >> sh;
        if (prod[127:64] != 0)
        begin
            sat = 1'b1;
            return '1;
        end
        return prod[63:0];
    endfunction

    // floor(num * 2^frac / den), saturating to 64 bits
    function automatic logic [63:0] div_scaled(input logic [63:0] num, input logic [63:0] den,
                                               input int frac, inout bit sat);
        logic [127:0] quo;
        quo = ({64'd0, num} << frac) / {64'd0, den};
        if (quo[127:64] != 0)
        begin
            sat = 1'b1;
            return '1;
        end
        return quo[63:0];
    endfunction

    function automatic longint clamp_force(input longint v, inout bit sat);
        longint hi;
        longint lo;
        hi = 64'sh7FFF_FFFF_FFFF;
        lo = -hi - 1;
        if (v > hi)
        begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // summed pair force on one atom
    function automatic out_item_t force_on(input int own);
        out_item_t    res;
        longint       acc [3];
        longint       d [3];
        logic [63:0]  mag [3];
        logic [64:0]  r2w;
        logic [63:0]  r2, s2, u, u2, u3, u6, a, b, w, c, p, g, m;
        bit           sat;
        bit           coin;
        bit           neg_w;
        int           n;
        longint       t;
        longint       hi;
        sat = 1'b0;
        coin = 1'b0;
        hi = 64'sh7FFF_FFFF_FFFF;
        acc = '{0, 0, 0};
        n = (n_atoms > TABLE_SIZE) ? TABLE_SIZE : int'(n_atoms);
        for (int i = 0; i < n; i++)
        begin
            if (i == own)
                continue;
            d[0] = longint'(atom_x[own]) - longint'(atom_x[i]);
            d[1] = longint'(atom_y[own]) - longint'(atom_y[i]);
            d[2] = longint'(atom_z[own]) - longint'(atom_z[i]);
            r2w = '0;
            for (int k = 0; k < 3; k++)
            begin
                mag[k] = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
                r2w = r2w + 65'(mag[k] * mag[k]);
                if (r2w[64])
                    r2w = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
            end
            r2 = r2w[63:0];
            if (r2 == 0)
            begin
                coin = 1'b1;
                continue;
            end
            s2 = 64'(sigma_q20) * 64'(sigma_q20);
            u  = div_scaled(s2, r2, 32, sat);
            u2 = mul_scaled(u, u, 32, sat);
            u3 = mul_scaled(u2, u, 32, sat);
            u6 = mul_scaled(u3, u3, 32, sat);
            a  = mul_scaled(u6, 64'd12, 0, sat);
            b  = mul_scaled(u3, 64'd6, 0, sat);
            neg_w = (a < b);
            w = neg_w ? b - a : a - b;
            c = LJ_K_Q40 * 64'(eps_q24);
            p = mul_scaled(c, w, 56, sat);
            g = div_scaled(p, r2, 40, sat);
            for (int k = 0; k < 3; k++)
            begin
                m = mul_scaled(g, mag[k], 28, sat);
                if (neg_w != (d[k] < 0))
                begin
                    if (m > 64'(hi) + 1)
                    begin
                        sat = 1'b1;
                        t = -hi - 1;
                    end
                    else
                        t = -longint'(m);
                end
                else
                begin
                    if (m > 64'(hi))
                    begin
                        sat = 1'b1;
                        t = hi;
                    end
                    else
                        t = longint'(m);
                end
                acc[k] = clamp_force(acc[k] + t, sat);
            end
        end
        res.force_x = acc[0][47:0];
        res.force_y = acc[1][47:0];
        res.force_z = acc[2][47:0];
        res.status = sat ? ST_SAT : (coin ? ST_COIN : ST_OK);
        return res;
    endfunction

    // apply one accepted transfer to the predictor state and return its result
    function automatic out_item_t predict_item(input in_item_t it);
        int idx;
        idx = int'(it.atom_index);
        if (it.op == OP_STORE)
        begin
            atom_x[idx] = it.pos_x;
            atom_y[idx] = it.pos_y;
            atom_z[idx] = it.pos_z;
            if (!stored[idx])
                stored_list.push_back(idx);
            stored[idx] = 1'b1;
            return '{force_x: '0, force_y: '0, force_z: '0, status: ST_OK};
        end
        return force_on(idx);
    endfunction

    // drive one input transfer and queue its expectation
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t pred;
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        pred = predict_item(it);
        force_queue.push_back(typed ? want : pred);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // wait for all results, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        in_valid <= 1'b0;
        wait (force_queue.size() == 0);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ATOM_COUNT: n_atoms = val[8:0];
            CFG_SIGMA:      sigma_q20 = val[23:0];
            default:        eps_q24 = val;
        endcase
    endtask

    function automatic in_item_t make_store(input int idx, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
        return '{op: OP_STORE, atom_index: 8'(idx), pos_x: x, pos_y: y, pos_z: z};
    endfunction

    function automatic in_item_t make_query(input int idx);
        return '{op: OP_QUERY, atom_index: 8'(idx), pos_x: $urandom, pos_y: $urandom,
                 pos_z: $urandom};
    endfunction

    function automatic stim_row_t row_cfg(input logic [1:0] idx, input logic [31:0] val);
        stim_row_t r;
        r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, item: '0, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t row_item(input in_item_t it, input bit typed);
        stim_row_t r;
        r = '{kind: ROW_ITEM, reg_idx: CFG_ATOM_COUNT, reg_val: '0, item: it, typed: typed,
              want: '{force_x: '0, force_y: '0, force_z: '0, status: ST_OK}};
        return r;
    endfunction

    // position coordinate: mostly within 16 angstrom of the origin per axis, sometimes any value
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endfunction

    // random store: free, near a stored atom, or right on top of one
    function automatic in_item_t rand_store(input int idx);
        int pick;
        int near;
        pick = $urandom_range(0, 19);
        if (stored_list.size() > 0 && pick < 9)
        begin
            near = stored_list[$urandom_range(0, stored_list.size() - 1)];
            if (pick == 0)
                return make_store(idx, atom_x[near], atom_y[near], atom_z[near]);
            return make_store(idx,
                atom_x[near] + 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000,
                atom_y[near] + 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000,
                atom_z[near] + 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000);
        end
        return make_store(idx, rand_coord(), rand_coord(), rand_coord());
    endfunction

    // random phase with a small atom set
    task automatic random_phase(input int send_pct, input int recv_pct, input int n_items);
        int count;
        int idx;
        send_gap_pct = send_pct;
        recv_stall_pct = recv_pct;
        count = $urandom_range(2, 10);
        write_reg(CFG_ATOM_COUNT, 32'(count));
        write_reg(CFG_SIGMA, ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(
            24'h20_0000, 24'h50_0000)));
        write_reg(CFG_EPSILON, ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(
            0, 32'h0200_0000)));
        for (int i = 0; i < count; i++)
            if (!stored[i])
                send_item(rand_store(i), 1'b0, '0);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 15);
                send_item(rand_store(idx), 1'b0, '0);
            end
            else
            begin
                idx = stored_list[$urandom_range(0, stored_list.size() - 1)];
                send_item(make_query(idx), 1'b0, '0);
            end
        end
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (force_queue.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $realtime, out_data);
                    errors++;
                end
                else
                begin
                    want = force_queue.pop_front();
                    if (out_data.force_x !== want.force_x)
                    begin
                        $display("%0t: force_x expected %h actual %h", $realtime,
                                 want.force_x, out_data.force_x);
                        errors++;
                    end
                    if (out_data.force_y !== want.force_y)
                    begin
                        $display("%0t: force_y expected %h actual %h", $realtime,
                                 want.force_y, out_data.force_y);
                        errors++;
                    end
                    if (out_data.force_z !== want.force_z)
                    begin
                        $display("%0t: force_z expected %h actual %h", $realtime,
                                 want.force_z, out_data.force_z);
                        errors++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 want.status, out_data.status);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] one_a;
        one_a = 32'h0010_0000;
        for (int i = 0; i < TABLE_SIZE; i++)
            stored[i] = 1'b0;

        // directed table: extremes, both operations, coincident, saturation, count limits
        directed.push_back(row_cfg(CFG_ATOM_COUNT, 32'd4));
        directed.push_back(row_item(make_store(0, 32'd0, 32'd0, 32'd0), 1'b1));
        directed.push_back(row_item(make_store(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                               32'h7FFF_FFFF), 1'b1));
        directed.push_back(row_item(make_store(2, 32'h8000_0000, 32'h8000_0000,
                                               32'h8000_0000), 1'b1));
        directed.push_back(row_item(make_store(3, 32'h0038_0000, 32'hFFFF_FFFF, one_a), 1'b1));
        directed.push_back(row_item(make_store(255, one_a, one_a, one_a), 1'b1));
        directed.push_back(row_item(make_query(0), 1'b0));
        directed.push_back(row_item(make_query(3), 1'b0));
        directed.push_back(row_item(make_query(1), 1'b0));
        directed.push_back(row_item(make_query(255), 1'b0));
        directed.push_back(row_cfg(CFG_ATOM_COUNT, 32'd1));
        directed.push_back(row_item(make_query(0), 1'b1));
        directed.push_back(row_cfg(CFG_ATOM_COUNT, 32'd5));
        directed.push_back(row_item(make_store(4, 32'd0, 32'd0, 32'd0), 1'b1));
        directed.push_back(row_item(make_query(0), 1'b0));
        directed.push_back(row_item(make_query(4), 1'b0));
        directed.push_back(row_cfg(CFG_SIGMA, 32'h00FF_FFFF));
        directed.push_back(row_item(make_query(3), 1'b0));
        directed.push_back(row_cfg(CFG_EPSILON, 32'd0));
        directed.push_back(row_item(make_query(3), 1'b0));
        directed.push_back(row_cfg(CFG_EPSILON, 32'hFFFF_FFFF));
        directed.push_back(row_item(make_query(3), 1'b0));
        directed.push_back(row_cfg(CFG_SIGMA, 32'd0));
        directed.push_back(row_item(make_query(1), 1'b0));
        directed.push_back(row_cfg(CFG_ATOM_COUNT, 32'd0));
        directed.push_back(row_item(make_query(2), 1'b1));
        directed.push_back(row_cfg(CFG_SIGMA, 32'(SIGMA_RST)));
        directed.push_back(row_cfg(CFG_EPSILON, 32'(EPS_RST)));

        // reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            else
                send_item(directed[i].item, directed[i].typed, directed[i].want);
        end

        // random traffic: sender idles lightly while the receiver stalls often, then the reverse, then no idling
        random_phase(6, 54, 9);
        random_phase(54, 6, 9);
        random_phase(0, 0, 9);

        // full table, count above the table size and at the table size
        send_gap_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < TABLE_SIZE; i++)
            if (!stored[i])
                send_item(rand_store(i), 1'b0, '0);
        write_reg(CFG_ATOM_COUNT, 32'h0000_01FF);
        send_item(make_query($urandom_range(0, 255)), 1'b0, '0);
        write_reg(CFG_ATOM_COUNT, 32'd256);
        send_item(make_query($urandom_range(0, 255)), 1'b0, '0);

        // drain
        @(posedge clk);
        in_valid <= 1'b0;
        wait (force_queue.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/ljfs_pkg.sv
rtl/ljfs_ram.sv
rtl/ljfs_div.sv
rtl/ljfs_mul.sv
rtl/lennard_jones_force_sum.sv
sim/tb_lennard_jones_force_sum.sv
